[hw/rtl/glob_pattern_matcher_top_assert.svh]
// Assertion macros shared by the checker modules of the glob pattern matcher.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef GLOB_PATTERN_MATCHER_TOP_ASSERT_SVH
`define GLOB_PATTERN_MATCHER_TOP_ASSERT_SVH

// cond holds at every clock edge
`define GPM_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante at an edge implies cons at the same edge
`define GPM_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante at an edge implies cons at the next edge
`define GPM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/gpm_pkg.sv]
`default_nettype none

package gpm_pkg;

    localparam int BYTE_W      = 8;
    localparam int ROW_W       = 32;
    localparam int OP_W        = 2;
    localparam int LEN_CFG_W   = 6;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int TABLE_DEPTH = 256;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_BEGIN = 2'd1,
        OP_BYTE  = 2'd2,
        OP_END   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 1'd0,
        CFG_STAR_MASK      = 1'd1
    } cfg_idx_t;

    // Pattern description as seen by the NFA update logic
    typedef struct packed {
        logic [LEN_CFG_W-1:0] pattern_length;
        logic [ROW_W-1:0]     star_mask;
    } gpm_cfg_t;

endpackage

`default_nettype wire

[hw/rtl/gpm_ram.sv]
`default_nettype none

module gpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gpm_nfa.sv]
`default_nettype none

module gpm_nfa
    import gpm_pkg::*;
#(
    parameter int MAX_POSITIONS = 32,
    localparam int N = MAX_POSITIONS + 1,
    localparam int LEN_W = $clog2(N)
) (
    input  wire gpm_cfg_t          cfg,
    input  wire logic              start,
    input  wire logic [N-1:0]      active,
    input  wire logic [ROW_W-1:0]  row,
    output logic      [N-1:0]      next_set,
    output logic                   matched
);

    localparam int EXT_W = (N > ROW_W) ? N : ROW_W;

    logic [7:0]       len_wide;
    logic [LEN_W-1:0] eff_len;
    logic [EXT_W-1:0] star_ext;
    logic [EXT_W-1:0] row_ext;
    logic [N-1:0]     live;
    logic [N-1:0]     sm;
    logic [N-1:0]     am;
    logic [N-1:0]     base;
    logic [N-1:0]     gen;
    logic [N-1:0]     sum;
    logic [N-1:0]     carry;

    always_comb
    begin
        // saturate the length at the number of positions
        len_wide = (8'(cfg.pattern_length) > 8'(MAX_POSITIONS)) ?
                   8'(MAX_POSITIONS) : 8'(cfg.pattern_length);
        eff_len  = len_wide[LEN_W-1:0];
        star_ext = EXT_W'(cfg.star_mask);
        row_ext  = EXT_W'(row);
        for (int i = 0; i < N; i++)
        begin
            live[i] = (LEN_W'(i) < eff_len);
        end
        sm = star_ext[N-1:0] & live;
        am = row_ext[N-1:0] & live;

        // stars loop on any byte, other live positions advance on a table hit
        if (start)
        begin
            base = N'(1);
        end
        else
        begin
            base = (active & sm) | ((active & ~sm & am) << 1);
        end

        // star closure as a carry chain: generate = active star, propagate = star
        gen      = base & sm;
        sum      = sm + gen;
        carry    = sum ^ sm ^ gen;
        next_set = base | carry;
    end

    assign matched = active[eff_len];

endmodule

`default_nettype wire

[hw/rtl/glob_pattern_matcher_top.sv]
// An end-of-string word is registered into stage 2 and then into the output register.
// Throughput: one input word per cycle unless stage 2 holds an end word while the
// output register is full. A byte's table read overlaps the prior word's NFA update.
// Reset: rst_n is asynchronous, active low; it clears the active set, both
// registers and all valid flags. The accept table is not cleared: load all rows.
`default_nettype none

module glob_pattern_matcher_top
    import gpm_pkg::*;
#(
    parameter int MAX_POSITIONS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] byte_value, [39:8] row_mask
    input  wire logic [OP_W-1:0]       s_tuser,   // [1:0] op
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,   // [0] matched, [7:1] zero
    // register write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int N = MAX_POSITIONS + 1;

    // Registers
    logic [LEN_CFG_W-1:0] pattern_length_reg;
    logic [ROW_W-1:0]     star_mask_reg;
    gpm_cfg_t             cfg;

    // Stage 1: accept a word, load a table row or issue the row read for a byte
    op_t              s_op;
    logic [BYTE_W-1:0] s_byte;
    logic [ROW_W-1:0]  s_row;
    logic              s_accept;

    // Stage 2: update the active set or produce a result
    logic        s2_valid_reg;
    logic        s2_valid_next;
    op_t         s2_op_reg;
    logic        s2_go;
    logic [ROW_W-1:0] row_rdata;

    logic [N-1:0] active_reg;
    logic [N-1:0] active_next;
    logic [N-1:0] nfa_next;
    logic         nfa_matched;

    // Output register
    logic out_valid_reg;
    logic out_valid_next;
    logic out_matched_reg;
    logic out_matched_next;

    assign cfg_ready = 1'b1;

    // Hold register writes; new values act on the next word at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
            star_mask_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_CFG_W-1:0];
                CFG_STAR_MASK:      star_mask_reg      <= cfg_data[ROW_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg.pattern_length = pattern_length_reg;
    assign cfg.star_mask      = star_mask_reg;

    assign s_op   = op_t'(s_tuser);
    assign s_byte = s_tdata[BYTE_W-1:0];
    assign s_row  = s_tdata[BYTE_W+ROW_W-1:BYTE_W];

    // Stage 2 stalls only on a result word that finds the output register full
    assign s2_go    = s2_valid_reg && (s2_op_reg != OP_END || !out_valid_reg || m_tready);
    assign s_tready = !s2_valid_reg || s2_go;
    assign s_accept = s_tvalid && s_tready;

    // Accept table: one row per byte value. A load is written at accept; a byte
    // word reads its row at accept, and the row arrives with the word in stage 2.
    // Words enter in order, one per cycle unless stalled, so reads see earlier loads.
    gpm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (s_accept && s_op == OP_LOAD),
        .waddr (s_byte),
        .wdata (s_row),
        .re    (s_accept && s_op == OP_BYTE),
        .raddr (s_byte),
        .rdata (row_rdata)
    );

    gpm_nfa #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_nfa (
        .cfg      (cfg),
        .start    (s2_op_reg == OP_BEGIN),
        .active   (active_reg),
        .row      (row_rdata),
        .next_set (nfa_next),
        .matched  (nfa_matched)
    );

    always_comb
    begin
        s2_valid_next = s_accept || (s2_valid_reg && !s2_go);

        // Advance the active set on begin and byte words, hold it otherwise
        active_next = active_reg;
        if (s2_go)
        begin
            case (s2_op_reg)
                OP_BEGIN, OP_BYTE: active_next = nfa_next;
                default:           active_next = active_reg;
            endcase
        end

        // Drop the result once taken; load a new one from an end-of-string word
        out_valid_next   = (out_valid_reg && !m_tready) || (s2_go && s2_op_reg == OP_END);
        out_matched_next = (s2_go && s2_op_reg == OP_END) ? nfa_matched : out_matched_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s2_op_reg <= s_op;
        end
        out_matched_reg <= out_matched_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_matched_reg);

endmodule

`default_nettype wire

[hw/rtl/gpm_checker.sv]
`default_nettype none

module gpm_checker
    import gpm_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [OP_W-1:0]      s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

`include "glob_pattern_matcher_top_assert.svh"

    // Upper result bits are padding
    `GPM_ASSERT_IMPLY(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:1] == '0, "result padding not zero")

    // A waiting result word stays until taken
    `GPM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result word dropped")

    // With the output register empty nothing can stall the input
    `GPM_ASSERT_IMPLY(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")

    // A fresh result comes from an end-of-string word accepted without a stall in stage 2
    `GPM_ASSERT_IMPLY(a_result_source, $rose(m_tvalid),
        $past(s_tvalid && s_tready && s_tuser == OP_END, 2), "result without end word")

endmodule

bind glob_pattern_matcher_top gpm_checker u_gpm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[verif/tb_glob_pattern_matcher_top.sv]
`timescale 1ns / 100ps

module tb_glob_pattern_matcher_top;
    import gpm_pkg::*;

    localparam int NUM_POS    = 32;
    localparam int NUM_WORDS  = 850;
    localparam int TIMEOUT_NS = 2_000_000;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] byte_value;
        logic [ROW_W-1:0]  row_mask;
    } gpm_word_t;

    typedef struct packed {
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    // ------------------------------------------------------------------
    // Block ports; every input is known from time zero
    // ------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;      // [7:0] byte_value, [39:8] row_mask
    logic [OP_W-1:0]       s_tuser = '0;      // [1:0] op
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;           // [0] matched, [7:1] zero
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    glob_pattern_matcher_top #(
        .MAX_POSITIONS(NUM_POS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    gpm_word_t   pending_words[$];    // words waiting for the stream driver
    reg_write_t  pending_regs[$];     // register writes waiting for the cfg driver
    bit          match_expect[$];     // predicted matched bits, oldest first

    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    bit          hold_req = 1'b0;
    bit          hold_ack = 1'b0;
    int unsigned hold_len = 0;
    int unsigned hold_left = 0;

    int unsigned mismatches = 0;
    int unsigned words_queued = 0;
    int unsigned words_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned matches_seen = 0;
    int unsigned strings_sent = 0;
    int unsigned regs_written = 0;

    task automatic report_mismatch(string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // NFA predictor: own copy of the table, the active set and registers
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]     accept_rows[TABLE_DEPTH];
    logic [NUM_POS:0]     nfa_active = '0;
    logic [LEN_CFG_W-1:0] len_reg_q = '0;
    logic [ROW_W-1:0]     star_reg_q = '0;

    // Length register saturates at the number of positions
    function automatic int unsigned live_len();
        return (len_reg_q > NUM_POS) ? NUM_POS : int'(len_reg_q);
    endfunction

    // Epsilon closure: an active star also activates its successor,
    // walking upward so that runs of stars chain through
    function automatic logic [NUM_POS:0] star_close(logic [NUM_POS:0] set);
        int unsigned n;
        n = live_len();
        for (int unsigned i = 0; i < n; i++)
            if (set[i] && star_reg_q[i])
                set[i+1] = 1'b1;
        return set;
    endfunction

    // Apply one accepted word; return the matched bit for an end word, else -1
    function automatic int nfa_step(gpm_word_t w);
        logic [NUM_POS:0] nxt;
        int unsigned n;
        n = live_len();
        nxt = '0;
        case (w.op)
            OP_LOAD:
                accept_rows[w.byte_value] = w.row_mask;
            OP_BEGIN:
                nfa_active = star_close({{NUM_POS{1'b0}}, 1'b1});
            OP_BYTE:
            begin
                for (int unsigned i = 0; i < n; i++)
                begin
                    if (nfa_active[i])
                    begin
                        // a star loops on any byte and ignores its table bit
                        if (star_reg_q[i])
                            nxt[i] = 1'b1;
                        else if (accept_rows[w.byte_value][i])
                            nxt[i+1] = 1'b1;
                    end
                end
                nfa_active = star_close(nxt);
            end
            OP_END:
                return nfa_active[n] ? 1 : 0;
            default: ;
        endcase
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // Stream driver: pop the next word, idle at the current rate
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : word_driver
        gpm_word_t w;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                w = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= w.op;
                s_tdata  <= {w.row_mask, w.byte_value};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Register write driver
    always @(posedge clk)
    begin : reg_driver
        reg_write_t w;
        if (!rst_n)
            cfg_valid <= 1'b0;
        else if (!cfg_valid || cfg_ready)
        begin
            if (pending_regs.size() != 0)
            begin
                w = pending_regs.pop_front();
                cfg_valid <= 1'b1;
                cfg_index <= w.idx;
                cfg_data  <= w.data;
            end
            else
                cfg_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted here in cycles; armed by toggling hold_req
    always @(posedge clk)
    begin : hold_counter
        if (hold_req != hold_ack)
        begin
            hold_left <= hold_len;
            hold_ack  <= hold_req;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result receiver: stall at random, and always during a hold-off
    always @(posedge clk)
    begin : result_receiver
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: check results first (they belong to older words), then
    // track register writes and predict from accepted input words
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        gpm_word_t seen;
        int        got;
        bit        want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (match_expect.size() == 0)
                    report_mismatch($sformatf("result %0d (matched=%b) with nothing expected",
                                              results_seen, m_tdata[0]));
                else
                begin
                    want = match_expect.pop_front();
                    if (m_tdata[0] !== want)
                        report_mismatch($sformatf("result %0d: matched=%b, predicted %b",
                                                  results_seen, m_tdata[0], want));
                end
                results_seen++;
                if (m_tdata[0] === 1'b1)
                    matches_seen++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_PATTERN_LENGTH: len_reg_q  = cfg_data[LEN_CFG_W-1:0];
                    CFG_STAR_MASK:      star_reg_q = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                seen.op         = op_t'(s_tuser);
                seen.byte_value = s_tdata[BYTE_W-1:0];
                seen.row_mask   = s_tdata[BYTE_W +: ROW_W];
                got = nfa_step(seen);
                if (got >= 0)
                    match_expect = {match_expect, got[0]};
                words_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus side: the current glob pattern, compiled as software would
    // ------------------------------------------------------------------
    logic [TABLE_DEPTH-1:0] pos_set[NUM_POS];   // bytes each position accepts
    logic [NUM_POS-1:0]     pos_star;
    int unsigned            pat_len;
    logic [BYTE_W-1:0]      alphabet[4];
    logic [ROW_W-1:0]       rows_sent[TABLE_DEPTH];

    task automatic push_word(op_t op, logic [BYTE_W-1:0] b, logic [ROW_W-1:0] row);
        gpm_word_t w;
        w.op = op;
        w.byte_value = b;
        w.row_mask = row;
        pending_words = {pending_words, w};
        words_queued++;
    endtask

    // Hold the sender until the block has drained, then let the tail settle
    // (an end word passes stage 2 and the output register before it surfaces)
    task automatic drain();
        while (pending_words.size() != 0 || s_tvalid || match_expect.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
        reg_write_t w;
        w.idx = idx;
        w.data = d;
        pending_regs = {pending_regs, w};
        while (pending_regs.size() != 0 || cfg_valid)
            @(negedge clk);
        regs_written++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        if ($urandom_range(4) != 0)
            b = alphabet[$urandom_range(3)];
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] byte_from(logic [TABLE_DEPTH-1:0] set);
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom);
        while (!set[b]);
        return b;
    endfunction

    // Table bits that matter: non-star positions below the length
    function automatic logic [ROW_W-1:0] live_bits();
        logic [ROW_W-1:0] m;
        m = '0;
        for (int unsigned i = 0; i < pat_len; i++)
            m[i] = !pos_star[i];
        return m;
    endfunction

    function automatic logic [ROW_W-1:0] wanted_row(int unsigned b);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int unsigned i = 0; i < pat_len; i++)
            r[i] = !pos_star[i] && pos_set[i][b];
        return r;
    endfunction

    // Load one row; fill star and unused bits with junk the block must ignore
    task automatic send_row(int unsigned b);
        logic [ROW_W-1:0] live;
        logic [ROW_W-1:0] junk;
        live = live_bits();
        junk = $urandom;
        rows_sent[b] = (wanted_row(b) & live) | (junk & ~live);
        push_word(OP_LOAD, BYTE_W'(b), rows_sent[b]);
    endtask

    // Reload the rows that differ (all of them when full is set), then
    // write both registers once the block is idle
    task automatic apply_pattern(bit full);
        logic [CFG_DATA_W-1:0] d;
        for (int unsigned b = 0; b < TABLE_DEPTH; b++)
            if (full || ((rows_sent[b] ^ wanted_row(b)) & live_bits()) != 0)
                send_row(b);
        drain();
        d = $urandom;
        for (int unsigned i = 0; i < pat_len; i++)
            d[i] = pos_star[i];
        write_reg(CFG_STAR_MASK, d);
        d = $urandom;
        d[LEN_CFG_W-1:0] = (pat_len == NUM_POS) ? LEN_CFG_W'($urandom_range(NUM_POS, 63))
                                                : LEN_CFG_W'(pat_len);
        write_reg(CFG_PATTERN_LENGTH, d);
    endtask

    // Random glob: literals, bracket sets, stars and, when allowed, '?'
    task automatic new_pattern(bit allow_any);
        int unsigned k;
        int unsigned r;
        for (int a = 0; a < 4; a++)
            alphabet[a] = BYTE_W'($urandom);
        if ($urandom_range(3) == 0)
            alphabet[0] = 8'h00;
        if ($urandom_range(3) == 0)
            alphabet[1] = 8'hFF;
        r = $urandom_range(9);
        pat_len = (r == 0) ? 0 : (r == 1) ? NUM_POS : $urandom_range(1, 8);
        pos_star = '0;
        for (int unsigned i = 0; i < NUM_POS; i++)
        begin
            pos_set[i] = '0;
            k = $urandom_range(99);
            if (i >= pat_len)
                continue;
            if (k < 20)
                pos_star[i] = 1'b1;
            else if (k < 30 && allow_any)
                pos_set[i] = '1;
            else if (k < 50)
                repeat ($urandom_range(2, 3)) pos_set[i][pick_byte()] = 1'b1;
            else
                pos_set[i][pick_byte()] = 1'b1;
        end
    endtask

    // One string: mostly a walk through the pattern, sometimes corrupted,
    // otherwise random bytes from the pattern's alphabet
    task automatic send_string(bit leave_open);
        logic [BYTE_W-1:0] s[$];
        int unsigned r;
        r = $urandom_range(9);
        if (r < 6)
        begin
            for (int unsigned i = 0; i < pat_len; i++)
            begin
                if (pos_star[i])
                    repeat ($urandom_range(2)) s = {s, pick_byte()};
                else
                    s = {s, byte_from(pos_set[i])};
            end
            if (r >= 4 && s.size() != 0)
            begin
                case ($urandom_range(2))
                    0:       s[$urandom_range(s.size() - 1)] = pick_byte();
                    1:       s.delete($urandom_range(s.size() - 1));
                    default: s = {s, pick_byte()};
                endcase
            end
        end
        else
            repeat ($urandom_range(6)) s = {s, pick_byte()};
        push_word(OP_BEGIN, BYTE_W'($urandom), $urandom);
        foreach (s[j])
            push_word(OP_BYTE, s[j], $urandom);
        if (!leave_open)
            push_word(OP_END, BYTE_W'($urandom), $urandom);
        strings_sent++;
    endtask

    // Words outside a clean begin..end sequence
    task automatic send_noise();
        case ($urandom_range(3))
            0:       push_word(OP_BYTE, pick_byte(), $urandom);            // stray byte
            1:       push_word(OP_END, BYTE_W'($urandom), $urandom);       // end, no fresh begin
            2:       push_word(OP_BEGIN, BYTE_W'($urandom), $urandom);     // doubled begin
            default: send_row(pick_byte());                                // row rewrite mid-stream
        endcase
    endtask

    // Idling mixes: none, sender 82%, receiver 82%, both 12%
    task automatic set_idling(int unsigned mode);
        case (mode)
            0:
            begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end
            1:
            begin
                tx_idle_pct = 82;
                rx_stall_pct = 0;
            end
            2:
            begin
                tx_idle_pct = 0;
                rx_stall_pct = 82;
            end
            default:
            begin
                tx_idle_pct = 12;
                rx_stall_pct = 12;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned phase;
        int unsigned n;
        int unsigned wait_cnt;
        bit          open_tail;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Opening pattern "**a?[\x00\xff]*": adjacent stars, literal, any,
        // set and a trailing star; load every row before any byte goes in
        pat_len = 6;
        pos_star = '0;
        for (int unsigned i = 0; i < NUM_POS; i++)
            pos_set[i] = '0;
        pos_star[0] = 1'b1;
        pos_star[1] = 1'b1;
        pos_star[5] = 1'b1;
        pos_set[2][8'h61] = 1'b1;
        pos_set[3] = '1;
        pos_set[4][8'h00] = 1'b1;
        pos_set[4][8'hFF] = 1'b1;
        for (int a = 0; a < 4; a++)
            alphabet[a] = 8'h61;
        apply_pattern(1'b1);

        // byte and end with no begin: the set is still empty after reset
        push_word(OP_BYTE, 8'h61, '1);
        push_word(OP_END, 8'hFF, '1);
        // shortest match, extremes of the set
        push_word(OP_BEGIN, 8'h00, '0);
        push_word(OP_BYTE, 8'h61, '1);
        push_word(OP_BYTE, 8'h7E, '0);
        push_word(OP_BYTE, 8'hFF, '1);
        push_word(OP_END, 8'h00, '0);
        // stars absorbing bytes at both ends
        push_word(OP_BEGIN, 8'hFF, '1);
        push_word(OP_BYTE, 8'h00, '0);
        push_word(OP_BYTE, 8'h61, '1);
        push_word(OP_BYTE, 8'h80, '0);
        push_word(OP_BYTE, 8'h00, '1);
        push_word(OP_BYTE, 8'h55, '0);
        push_word(OP_BYTE, 8'hFF, '1);
        push_word(OP_END, 8'h00, '0);
        // shorten the pattern to "**" in the middle of a string
        push_word(OP_BEGIN, 8'h00, '0);
        push_word(OP_BYTE, 8'h61, '0);
        drain();
        write_reg(CFG_PATTERN_LENGTH, 32'd2);
        push_word(OP_END, 8'h00, '0);
        // "**" against the empty string
        push_word(OP_BEGIN, 8'h00, '0);
        push_word(OP_END, 8'h00, '0);
        drain();
        // all stars, length field at its top value (saturates)
        write_reg(CFG_STAR_MASK, '1);
        write_reg(CFG_PATTERN_LENGTH, '1);
        push_word(OP_BEGIN, 8'h00, '0);
        push_word(OP_BYTE, 8'h33, '1);
        push_word(OP_END, 8'h00, '0);
        drain();
        // empty pattern, empty string
        write_reg(CFG_STAR_MASK, '0);
        write_reg(CFG_PATTERN_LENGTH, '0);
        push_word(OP_BEGIN, 8'h00, '1);
        push_word(OP_END, 8'h00, '1);
        drain();

        // Back-pressure: arm the receiver hold-off while short strings
        // keep coming, so the block fills and stalls its input
        hold_len = 400;
        hold_req = ~hold_req;
        repeat (12)
        begin
            push_word(OP_BEGIN, BYTE_W'($urandom), $urandom);
            if ($urandom_range(1) != 0)
                push_word(OP_BYTE, BYTE_W'($urandom), $urandom);
            push_word(OP_END, BYTE_W'($urandom), $urandom);
            strings_sent++;
        end
        drain();

        // Random phases: new pattern each time, cycling through idling mixes;
        // a phase may end mid-string so the next register writes land inside it
        phase = 0;
        open_tail = 1'b0;
        while (words_queued < NUM_WORDS)
        begin
            set_idling(phase % 4);
            new_pattern(words_queued < 450 && $urandom_range(4) == 0);
            apply_pattern(1'b0);
            if (open_tail)
            begin
                repeat ($urandom_range(2)) push_word(OP_BYTE, pick_byte(), $urandom);
                push_word(OP_END, BYTE_W'($urandom), $urandom);
            end
            open_tail = ($urandom_range(3) == 0);
            n = $urandom_range(6, 14);
            for (int unsigned j = 0; j < n; j++)
            begin
                if ($urandom_range(9) == 0)
                    send_noise();
                send_string(j == n - 1 && open_tail);
            end
            drain();
            phase++;
        end
        if (open_tail)
            push_word(OP_END, BYTE_W'($urandom), $urandom);

        // Wait out the last words and results, bounded
        wait_cnt = 0;
        while ((pending_words.size() != 0 || s_tvalid || match_expect.size() != 0)
               && wait_cnt < 100000)
        begin
            @(negedge clk);
            wait_cnt++;
        end
        repeat (10) @(negedge clk);
        if (match_expect.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      match_expect.size()));

        $display("Run covered %0d input words, %0d strings, %0d register writes, %0d phases.",
                 words_accepted, strings_sent, regs_written, phase);
        $display("Checked %0d results (%0d matches); %0d mismatches.",
                 results_seen, matches_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule
